### rtl/wnst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnst_pkg - shared types and constants of the wheel null-space torque block
// Holds the datapath phase codes, the command and status bundles between the
// controller and the datapath, and the interface codes.
// ----------------------------------------------------------------------------
package wnst_pkg;

  localparam int MAX_WHEELS_DEF  = 8;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int OPW             = 32;  // multiplier operand width
  localparam int IDX_W           = 3;   // wheel / matrix index in a command
  localparam int CNT_W           = 4;   // loop counts up to eight
  localparam int GAIN_W          = 31;
  localparam int WCNT_W          = 4;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_COUNT = 1'b1;

  localparam logic OP_LOAD_AXIS   = 1'b0;
  localparam logic OP_LOAD_SAMPLE = 1'b1;

  localparam logic KIND_TORQUE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_GRAM,   // Gram matrix G G^T
    PH_COF,    // cofactors
    PH_DET,    // determinant
    PH_INV,    // inverse entries through the divider
    PH_TMAT,   // T = inv * G
    PH_PROJ,   // P = I - G^T T
    PH_DVEC,   // speed feedback vector
    PH_TORQ    // torque rows
  } phase_t;

  typedef struct packed {
    logic             valid;
    phase_t           phase;
    logic [IDX_W-1:0] o1;
    logic [IDX_W-1:0] o2;
    logic [IDX_W-1:0] k;
    logic             first;
    logic             last;
    logic             clr_proj;
    logic             ld_axis;
    logic             ld_sample;
  } dp_cmd_t;

  typedef struct packed {
    logic wb_torq;
    logic div_done;
    logic det_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/wnst_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnst_div - fixed-point divider
// Computes (num * 2^16) / den truncated toward zero and saturated, one
// quotient bit per cycle with a restoring shift-subtract loop.
// ----------------------------------------------------------------------------
module wnst_div #(
  parameter int DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic                      done,
  output logic signed [DW-1:0]      quo
);
  import wnst_pkg::*;

  localparam int NB = DW + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);
  localparam logic [NB:0] ONE_X   = 1;
  localparam logic [NB:0] LIM_NEG = ONE_X << (DW - 1);
  localparam logic [NB:0] LIM_POS = LIM_NEG - ONE_X;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NB-1:0] sh_r, sh_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [DW-1:0] num_mag, den_mag;
  logic [DW:0]   trial, diff;
  logic          ge;
  logic [NB:0]   qx;

  always_comb begin
    num_mag  = num[DW-1] ? DW'(-num) : DW'(num);
    den_mag  = den[DW-1] ? DW'(-den) : DW'(den);
    trial    = {rem_r, sh_r[NB-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NB);
      rem_nxt  = '0;
      sh_nxt   = {num_mag, {FRAC_BITS{1'b0}}};
      den_nxt  = den_mag;
      neg_nxt  = num[DW-1] ^ den[DW-1];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_nxt  = {sh_r[NB-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Sign and saturate the magnitude quotient.
  always_comb begin
    qx = {1'b0, sh_r};
    if (neg_r) begin
      quo = (qx > LIM_NEG) ? {1'b1, {(DW-1){1'b0}}} : DW'(-qx);
    end else begin
      quo = (qx > LIM_POS) ? {1'b0, {(DW-1){1'b1}}} : qx[DW-1:0];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

### rtl/wnst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnst_dp - datapath of the wheel null-space torque block
// Holds the axis and sample stores, the 3x3 intermediates, the projection
// memory, one shared multiply-accumulate pipe and the divider.
// ----------------------------------------------------------------------------
module wnst_dp #(
  parameter int NW = 8,
  parameter int DW = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wnst_pkg::dp_cmd_t             cmd,
  output wnst_pkg::dp_stat_t                 stat,
  input  wire logic [wnst_pkg::IDX_W-1:0]    in_wheel,
  input  wire logic signed [31:0]            in_axis_x,
  input  wire logic signed [31:0]            in_axis_y,
  input  wire logic signed [31:0]            in_axis_z,
  input  wire logic signed [31:0]            in_wheel_speed,
  input  wire logic signed [31:0]            in_desired_speed,
  input  wire logic signed [31:0]            in_request_torque,
  input  wire logic [wnst_pkg::GAIN_W-1:0]   speed_gain,
  output logic signed [DW-1:0]               torque
);
  import wnst_pkg::*;

  localparam int IW = $clog2(NW);
  localparam int AW = DW + 4;
  localparam int PD = 1 << (2 * IW);
  localparam logic signed [DW-1:0] EYE =
    (DW > 17) ? DW'(65536) : {1'b0, {(DW-1){1'b1}}};

  function automatic logic signed [DW-1:0] sat64(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (DW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return hi[DW-1:0];
    else if (x < lo) return lo[DW-1:0];
    else return x[DW-1:0];
  endfunction

  function automatic logic signed [OPW-1:0] ext(input logic signed [DW-1:0] x);
    return OPW'(x);
  endfunction

  function automatic logic [1:0] nx3(input logic [1:0] x);
    case (x)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // Stores and intermediates
  logic signed [DW-1:0] ax_r   [NW][3];
  logic signed [DW-1:0] err_r  [NW];
  logic signed [DW-1:0] req_r  [NW];
  logic signed [DW-1:0] m_r    [3][3];
  logic signed [DW-1:0] cof_r  [3][3];
  logic signed [DW-1:0] inv_r  [3][3];
  logic signed [DW-1:0] t_r    [3][NW];
  logic signed [DW-1:0] d_r    [NW];
  logic signed [DW-1:0] det_r;
  logic signed [DW-1:0] torque_r;
  logic signed [DW-1:0] proj_mem [PD];
  logic [PD-1:0]        pvalid_r;

  // Pipe
  dp_cmd_t               cmd1_r, cmd2_r, cmd3_r;
  logic signed [OPW-1:0] opa_r, opb_r, opa_nxt, opb_nxt, mult_a;
  logic                  neg1_r, neg2_r, neg_nxt;
  logic signed [DW-1:0]  proj_q_r;
  logic                  pv1_r, eye1_r;
  logic signed [2*OPW-1:0] prod_r;
  logic signed [AW-1:0]  acc_r, acc_nxt, term_ext;
  logic signed [63:0]    sh;
  logic signed [DW-1:0]  term, res;
  logic [1:0]            a1, a2, b1, b2;
  logic [IW-1:0]         ik, io1, io2, iw;
  logic [2*IW-1:0]       rd_addr, wr_addr;

  // Divider
  logic                  div_start, div_done;
  logic signed [DW-1:0]  div_q;
  logic [1:0]            div_i_r, div_j_r;

  assign ik        = cmd.k[IW-1:0];
  assign io1       = cmd.o1[IW-1:0];
  assign io2       = cmd.o2[IW-1:0];
  assign iw        = in_wheel[IW-1:0];
  assign rd_addr   = {io1, ik};
  assign wr_addr   = {cmd3_r.o1[IW-1:0], cmd3_r.o2[IW-1:0]};
  assign div_start = cmd.valid && (cmd.phase == PH_INV);

  wnst_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cof_r[cmd.o2[1:0]][cmd.o1[1:0]]),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Operand selection
  always_comb begin
    a1      = nx3(cmd.o1[1:0]);
    a2      = nx3(a1);
    b1      = nx3(cmd.o2[1:0]);
    b2      = nx3(b1);
    opa_nxt = '0;
    opb_nxt = '0;
    neg_nxt = 1'b0;
    case (cmd.phase)
      PH_GRAM: begin
        opa_nxt = ext(ax_r[ik][cmd.o1[1:0]]);
        opb_nxt = ext(ax_r[ik][cmd.o2[1:0]]);
      end
      PH_COF: begin
        if (cmd.first) begin
          opa_nxt = ext(m_r[a1][b1]);
          opb_nxt = ext(m_r[a2][b2]);
        end else begin
          opa_nxt = ext(m_r[a1][b2]);
          opb_nxt = ext(m_r[a2][b1]);
          neg_nxt = 1'b1;
        end
      end
      PH_DET: begin
        opa_nxt = ext(m_r[0][cmd.k[1:0]]);
        opb_nxt = ext(cof_r[0][cmd.k[1:0]]);
      end
      PH_TMAT: begin
        opa_nxt = ext(inv_r[cmd.o1[1:0]][cmd.k[1:0]]);
        opb_nxt = ext(ax_r[io2][cmd.k[1:0]]);
      end
      PH_PROJ: begin
        opa_nxt = ext(ax_r[io1][cmd.k[1:0]]);
        opb_nxt = ext(t_r[cmd.k[1:0]][io2]);
      end
      PH_DVEC: begin
        opa_nxt = $signed({1'b0, speed_gain});
        opb_nxt = ext(err_r[io1]);
        neg_nxt = 1'b1;
      end
      PH_TORQ: begin
        opb_nxt = ext(d_r[ik]);
      end
      default: begin
        opa_nxt = '0;
      end
    endcase
  end

  // Product scaling and accumulation
  always_comb begin
    if (cmd1_r.phase == PH_TORQ) begin
      mult_a = pv1_r ? ext(proj_q_r) : (eye1_r ? ext(EYE) : '0);
    end else begin
      mult_a = opa_r;
    end
    sh       = prod_r >>> FRAC_BITS;
    term     = sat64(sh);
    term_ext = AW'(term);
    acc_nxt  = (cmd2_r.first ? '0 : acc_r) + (neg2_r ? -term_ext : term_ext);
    res      = sat64(64'(acc_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd1_r <= '0;
      cmd2_r <= '0;
      cmd3_r <= '0;
    end else begin
      cmd1_r <= cmd;
      cmd2_r <= cmd1_r;
      cmd3_r <= cmd2_r;
    end
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    neg1_r   <= neg_nxt;
    neg2_r   <= neg1_r;
    prod_r   <= mult_a * opb_r;
    acc_r    <= acc_nxt;
    pv1_r    <= pvalid_r[rd_addr];
    eye1_r   <= (io1 == ik);
  end

  // Projection memory
  always_ff @(posedge clk) begin
    proj_q_r <= proj_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd3_r.valid && cmd3_r.last && (cmd3_r.phase == PH_PROJ)) begin
      proj_mem[wr_addr] <= sat64(64'((cmd3_r.o1 == cmd3_r.o2) ? EYE : '0) - 64'(res));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_proj) begin
      pvalid_r <= '0;
    end else if (cmd3_r.valid && cmd3_r.last && (cmd3_r.phase == PH_PROJ)) begin
      pvalid_r[wr_addr] <= 1'b1;
    end
  end

  // Axis store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NW; w++) begin
        for (int c = 0; c < 3; c++) begin
          ax_r[w][c] <= '0;
        end
      end
    end else if (cmd.ld_axis && (32'(in_wheel) < NW)) begin
      ax_r[iw][0] <= sat64(64'(in_axis_x));
      ax_r[iw][1] <= sat64(64'(in_axis_y));
      ax_r[iw][2] <= sat64(64'(in_axis_z));
    end
  end

  // Sample stores and results of the pipe
  always_ff @(posedge clk) begin
    if (cmd.ld_sample && (32'(in_wheel) < NW)) begin
      err_r[iw] <= sat64(64'(in_wheel_speed) - 64'(in_desired_speed));
      req_r[iw] <= sat64(64'(in_request_torque));
    end
    if (div_start) begin
      div_i_r <= cmd.o1[1:0];
      div_j_r <= cmd.o2[1:0];
    end
    if (div_done) begin
      inv_r[div_i_r][div_j_r] <= div_q;
    end
    if (cmd3_r.valid && cmd3_r.last) begin
      case (cmd3_r.phase)
        PH_GRAM: m_r[cmd3_r.o1[1:0]][cmd3_r.o2[1:0]]   <= res;
        PH_COF:  cof_r[cmd3_r.o1[1:0]][cmd3_r.o2[1:0]] <= res;
        PH_DET:  det_r <= res;
        PH_TMAT: t_r[cmd3_r.o1[1:0]][cmd3_r.o2[IW-1:0]] <= res;
        PH_DVEC: d_r[cmd3_r.o1[IW-1:0]] <= res;
        PH_TORQ: torque_r <= sat64(64'(req_r[cmd3_r.o1[IW-1:0]]) + 64'(res));
        default: ;
      endcase
    end
  end

  assign stat.wb_torq  = cmd3_r.valid && cmd3_r.last && (cmd3_r.phase == PH_TORQ);
  assign stat.div_done = div_done;
  assign stat.det_zero = (det_r == '0);
  assign torque        = torque_r;

endmodule
`default_nettype wire

### rtl/wnst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnst_ctrl - controller of the wheel null-space torque block
// Sequences the loops of each phase into datapath commands, drains the pipe
// between phases and owns the result handshake and the singular flag.
// ----------------------------------------------------------------------------
module wnst_ctrl #(
  parameter int NW = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_opcode,
  input  wire logic                          in_last,
  output logic                               in_ready,
  input  wire logic [wnst_pkg::WCNT_W-1:0]   wheel_count,
  output wnst_pkg::dp_cmd_t                  cmd,
  input  wire wnst_pkg::dp_stat_t            stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic [wnst_pkg::IDX_W-1:0]         out_wheel,
  output logic                               out_singular,
  output logic                               out_final
);
  import wnst_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_DIVW, S_STAT} state_t;

  localparam logic [1:0] DRAIN_LEN = 2'd3;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  o1_r, o1_nxt, o2_r, o2_nxt, k_r, k_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt, n_act;
  logic [CNT_W-1:0]  l1, l2, lk;
  logic [1:0]        drain_r, drain_nxt;
  logic              sing_r, sing_nxt;
  logic              ov_r, ov_nxt, okind_r, okind_nxt, ofinal_r, ofinal_nxt;
  logic              osing_r, osing_nxt;
  logic [IDX_W-1:0]  owheel_r, owheel_nxt;
  logic              accept, slot_free, k_last, outer_last, o2_last;

  assign n_act = (32'(wheel_count) > NW) ? CNT_W'(NW) : CNT_W'(wheel_count);

  always_comb begin
    case (phase_r)
      PH_GRAM: begin l1 = CNT_W'(3); l2 = CNT_W'(3); lk = n_r;        end
      PH_COF:  begin l1 = CNT_W'(3); l2 = CNT_W'(3); lk = CNT_W'(2);  end
      PH_DET:  begin l1 = CNT_W'(1); l2 = CNT_W'(1); lk = CNT_W'(3);  end
      PH_INV:  begin l1 = CNT_W'(3); l2 = CNT_W'(3); lk = CNT_W'(1);  end
      PH_TMAT: begin l1 = CNT_W'(3); l2 = n_r;       lk = CNT_W'(3);  end
      PH_PROJ: begin l1 = n_r;       l2 = n_r;       lk = CNT_W'(3);  end
      PH_DVEC: begin l1 = n_r;       l2 = CNT_W'(1); lk = CNT_W'(1);  end
      PH_TORQ: begin l1 = n_r;       l2 = CNT_W'(1); lk = n_r;        end
      default: begin l1 = CNT_W'(1); l2 = CNT_W'(1); lk = CNT_W'(1);  end
    endcase
  end

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !ov_r || out_ready;
  assign k_last     = (k_r + CNT_W'(1)) == lk;
  assign o2_last    = (o2_r + CNT_W'(1)) == l2;
  assign outer_last = ((o1_r + CNT_W'(1)) == l1) && o2_last;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    o1_nxt     = o1_r;
    o2_nxt     = o2_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    drain_nxt  = drain_r;
    sing_nxt   = sing_r;
    ov_nxt     = ov_r;
    okind_nxt  = okind_r;
    owheel_nxt = owheel_r;
    ofinal_nxt = ofinal_r;
    osing_nxt  = osing_r;
    cmd        = '0;
    cmd.phase  = phase_r;
    cmd.o1     = o1_r[IDX_W-1:0];
    cmd.o2     = o2_r[IDX_W-1:0];
    cmd.k      = k_r[IDX_W-1:0];
    cmd.first  = (k_r == '0);
    cmd.last   = k_last;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    // Torque row written back: present it
    if (stat.wb_torq) begin
      ov_nxt     = 1'b1;
      okind_nxt  = KIND_TORQUE;
      owheel_nxt = o1_r[IDX_W-1:0];
      ofinal_nxt = (o1_r + CNT_W'(1)) == n_r;
      osing_nxt  = sing_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_axis   = (in_opcode == OP_LOAD_AXIS);
          cmd.ld_sample = (in_opcode == OP_LOAD_SAMPLE);
          if (in_last) begin
            n_nxt  = n_act;
            o1_nxt = '0;
            o2_nxt = '0;
            k_nxt  = '0;
            if (in_opcode == OP_LOAD_AXIS) begin
              cmd.clr_proj = 1'b1;
              sing_nxt     = 1'b1;
              if (n_act == '0) begin
                state_nxt = S_STAT;
              end else begin
                phase_nxt = PH_GRAM;
                state_nxt = S_ISSUE;
              end
            end else if (n_act != '0) begin
              phase_nxt = PH_DVEC;
              state_nxt = S_ISSUE;
            end
          end
        end
      end
      S_ISSUE: begin
        // hold a torque row until the result register can take it
        if (!((phase_r == PH_TORQ) && (k_r == '0) && !slot_free)) begin
          cmd.valid = 1'b1;
          if (phase_r == PH_INV) begin
            state_nxt = S_DIVW;
          end else if (k_last) begin
            k_nxt = '0;
            if ((phase_r == PH_TORQ) || outer_last) begin
              state_nxt = S_DRAIN;
              drain_nxt = DRAIN_LEN;
            end else if (o2_last) begin
              o2_nxt = '0;
              o1_nxt = o1_r + CNT_W'(1);
            end else begin
              o2_nxt = o2_r + CNT_W'(1);
            end
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end
      end
      S_DRAIN: begin
        if (drain_r != '0) begin
          drain_nxt = drain_r - 2'd1;
        end else if (phase_r == PH_TORQ) begin
          if ((o1_r + CNT_W'(1)) == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            o1_nxt    = o1_r + CNT_W'(1);
            state_nxt = S_ISSUE;
          end
        end else begin
          o1_nxt    = '0;
          o2_nxt    = '0;
          k_nxt     = '0;
          state_nxt = S_ISSUE;
          case (phase_r)
            PH_GRAM: phase_nxt = PH_COF;
            PH_COF:  phase_nxt = PH_DET;
            PH_DET: begin
              if (stat.det_zero) state_nxt = S_STAT;
              else phase_nxt = PH_INV;
            end
            PH_TMAT: phase_nxt = PH_PROJ;
            PH_PROJ: begin
              sing_nxt  = 1'b0;
              state_nxt = S_STAT;
            end
            PH_DVEC: phase_nxt = PH_TORQ;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_nxt = S_ISSUE;
          if (outer_last) begin
            phase_nxt = PH_TMAT;
            o1_nxt    = '0;
            o2_nxt    = '0;
          end else if (o2_last) begin
            o2_nxt = '0;
            o1_nxt = o1_r + CNT_W'(1);
          end else begin
            o2_nxt = o2_r + CNT_W'(1);
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = KIND_STATUS;
          owheel_nxt = '0;
          ofinal_nxt = 1'b1;
          osing_nxt  = sing_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_GRAM;
      o1_r    <= '0;
      o2_r    <= '0;
      k_r     <= '0;
      n_r     <= '0;
      drain_r <= '0;
      sing_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      o1_r    <= o1_nxt;
      o2_r    <= o2_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      drain_r <= drain_nxt;
      sing_r  <= sing_nxt;
      ov_r    <= ov_nxt;
    end
    okind_r  <= okind_nxt;
    owheel_r <= owheel_nxt;
    ofinal_r <= ofinal_nxt;
    osing_r  <= osing_nxt;
  end

  assign out_valid    = ov_r;
  assign out_kind     = okind_r;
  assign out_wheel    = owheel_r;
  assign out_singular = osing_r;
  assign out_final    = ofinal_r;

endmodule
`default_nettype wire

### rtl/wheel_null_space_torque.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_null_space_torque - reaction wheel null-space torque distribution
// Builds the null-space projection I - G^T (G G^T)^-1 G from the wheel spin
// axes and adds the projected speed feedback to each wheel's torque request.
// ----------------------------------------------------------------------------
// An item without tlast is stored and the block stays ready for more.
// In a sample run with n active wheels one shared multiplier does every
// product, n products for the speed feedback vector and one row of n
// products per wheel, and each row drains the multiply-accumulate pipe
// before its result shows. In an axis run the nine inverse entries
// dominate, each one passing through a divider that makes one quotient bit
// per cycle. A zero determinant ends the run after the determinant and
// reports singular with an identity projection. Results leave through a
// registered output; the block takes no item while a run is in progress.
module wheel_null_space_torque #(
  parameter int MAX_WHEELS  = wnst_pkg::MAX_WHEELS_DEF,
  parameter int VALUE_WIDTH = wnst_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // wheel_index[2:0], axis_x[34:3], axis_y[66:35], axis_z[98:67],
  // wheel_speed[130:99], desired_speed[162:131], request_torque[194:163]
  input  wire logic [199:0]                      in_tdata,
  input  wire logic                              in_tuser,  // opcode
  input  wire logic                              in_tlast,  // last
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_wheel[2:0], motor_torque[34:3], singular[35]
  output logic [39:0]                            out_tdata,
  output logic                                   out_tuser, // result_kind
  output logic                                   out_tlast, // final_res
  input  wire logic                              cfg_wr_en,
  input  wire logic [wnst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [30:0]                       cfg_wdata
);
  import wnst_pkg::*;

  localparam int NW = (MAX_WHEELS < 8) ? MAX_WHEELS : 8;
  localparam int DW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  logic [GAIN_W-1:0]    speed_gain_r;
  logic [WCNT_W-1:0]    wheel_count_r;
  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic signed [DW-1:0] torque;
  logic                 o_kind, o_sing;
  logic [IDX_W-1:0]     o_wheel;
  logic [31:0]          torque_field;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gain_r  <= '0;
      wheel_count_r <= WCNT_W'(4);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SPEED_GAIN:  speed_gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_WHEEL_COUNT: wheel_count_r <= cfg_wdata[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  wnst_ctrl #(.NW(NW)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_opcode    (in_tuser),
    .in_last      (in_tlast),
    .in_ready     (in_tready),
    .wheel_count  (wheel_count_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_kind     (o_kind),
    .out_wheel    (o_wheel),
    .out_singular (o_sing),
    .out_final    (out_tlast)
  );

  wnst_dp #(.NW(NW), .DW(DW)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_wheel          (in_tdata[2:0]),
    .in_axis_x         (in_tdata[34:3]),
    .in_axis_y         (in_tdata[66:35]),
    .in_axis_z         (in_tdata[98:67]),
    .in_wheel_speed    (in_tdata[130:99]),
    .in_desired_speed  (in_tdata[162:131]),
    .in_request_torque (in_tdata[194:163]),
    .speed_gain        (speed_gain_r),
    .torque            (torque)
  );

  // status results carry no torque
  assign torque_field = (o_kind == KIND_STATUS) ? 32'd0 : 32'(torque);
  assign out_tdata    = {4'd0, o_sing, torque_field, o_wheel};
  assign out_tuser    = o_kind;

endmodule
`default_nettype wire

### rtl/wnst_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnst_chk - port checker for the wheel null-space torque block
// Watches the result channel and input ready of the top level and flags bad results.
// ----------------------------------------------------------------------------
module wnst_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // a status result is always the final one and carries no torque or wheel
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[34:0] == 35'd0))
    else $error("malformed status result");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // reset leaves the input ready for a transaction
  a_in_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind wheel_null_space_torque wnst_chk u_wnst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
